@@ rtl/lbps_pkg.sv @@
// Package for the LED blink pattern sequencer.
// Holds action codes, priority codes, item layouts and table geometry.
// No dependencies.
package lbps_pkg;

  localparam int unsigned PAT_W      = 4;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned NUM_PATS   = 16;
  localparam int unsigned SLOT_ADDR_W = PAT_W + SLOT_W;
  localparam int unsigned SLOT_DEPTH = NUM_PATS * (1 << SLOT_W);
  localparam int unsigned DUR_W      = 8;
  localparam int unsigned CD_W       = 12;
  localparam logic [CD_W-1:0] START_GAP_MS = 12'd10;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_START  = 3'd1,
    ACT_STOP   = 3'd2,
    ACT_WR_HDR = 3'd3,
    ACT_WR_SLOT = 3'd4
  } action_t;

  localparam logic [1:0] PRIO_SAVE = 2'd1;
  localparam logic [1:0] PRIO_LOCK = 2'd2;

  // Input item payload, last field in the lowest bits.
  typedef struct packed {
    logic       green_enable;
    logic       red_enable;
    logic [7:0] repeats;
    logic [1:0] priority_req;
    logic [3:0] slot_count;
    logic [7:0] duration;
    logic [3:0] slot_index;
    logic [3:0] pattern;
  } in_item_t;

  // Result item payload, padded to a byte.
  typedef struct packed {
    logic       pad;
    logic [3:0] active_pattern;
    logic       busy_res;
    logic       green_led;
    logic       red_led;
  } out_item_t;

  // Pattern header as stored in the table.
  typedef struct packed {
    logic [7:0] repeats;
    logic       green_en;
    logic       red_en;
    logic [1:0] prio;
    logic [3:0] slot_count;
  } header_t;

endpackage

@@ rtl/lbps_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lbps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/led_blink_pattern_sequencer.sv @@
// LED blink pattern sequencer: each accepted item's result is registered in the result
// register, or in the skid register during an output stall. Throughput: one item per
// cycle while the skid register is empty; the slot duration RAM is read from the next
// state, so each tick step finds its duration already registered. The two-entry output
// lets one more item in during a stall. Reset (rst_n low, synchronous) clears all state,
// both tables read as zero, both LEDs are marked fitted; no clearing pass is needed.
module led_blink_pattern_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // pattern, slot_index, duration, slot_count,
                                 // priority_req, repeats, red_enable, green_enable
  input  logic [2:0]  in_tuser,  // action
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata, // red_led, green_led, busy_res, active_pattern, zero pad
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_addr,  // 0 red_fitted, 1 green_fitted
  input  logic        cfg_wdata
);
  import lbps_pkg::*;

  localparam logic CFG_RED   = 1'b0;
  localparam logic CFG_GREEN = 1'b1;

  in_item_t item;
  action_t  act;
  logic     in_fire;
  logic     out_fire;

  assign item     = in_item_t'(in_tdata);
  assign act      = action_t'(in_tuser);
  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic red_fitted_r, green_fitted_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_fitted_r   <= 1'b1;
      green_fitted_r <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_RED:   red_fitted_r   <= cfg_wdata;
        CFG_GREEN: green_fitted_r <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  logic [PAT_W-1:0]  line_r, line_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [7:0]        round_r, round_nxt;
  logic [PAT_W-1:0]  sv_line_r, sv_line_nxt;
  logic [SLOT_W-1:0] sv_slot_r, sv_slot_nxt;
  logic [7:0]        sv_round_r, sv_round_nxt;
  logic [CD_W-1:0]   cd_r, cd_nxt;
  logic [1:0]        led_r, led_nxt;

  // Header table: small, read at the active pattern only.
  header_t hdr_r [NUM_PATS];
  logic    hdr_we;

  // Slot duration RAM plus per-entry valid bits (unwritten entries read zero).
  logic [SLOT_DEPTH-1:0]  slot_vld_r;
  logic                   slot_we;
  logic [SLOT_ADDR_W-1:0] slot_waddr;
  logic [SLOT_ADDR_W-1:0] slot_raddr;
  logic [DUR_W-1:0]       ram_q;
  logic                   rd_vld_r;
  logic                   fwd_hit_r;
  logic [DUR_W-1:0]       fwd_data_r;
  logic [DUR_W-1:0]       dur_cur;

  lbps_ram #(
    .WIDTH (DUR_W),
    .DEPTH (SLOT_DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (item.duration),
    .raddr (slot_raddr),
    .rdata (ram_q)
  );

  // Duration of the slot that the next step would enter.
  assign dur_cur = fwd_hit_r ? fwd_data_r : (rd_vld_r ? ram_q : '0);

  header_t          hdr_cur;
  logic [CD_W-1:0]  cd_dec;
  logic [CD_W-1:0]  dur_ms;
  logic [SLOT_W-1:0] slot_inc;

  function automatic logic [CD_W-2:0] item_dur_x8(input logic [DUR_W-1:0] d);
    item_dur_x8 = {d, 3'b000};
  endfunction

  assign hdr_cur  = hdr_r[line_r];
  assign cd_dec   = (cd_r != '0) ? cd_r - 1'b1 : cd_r;
  // duration * 10 as shift-and-add
  assign dur_ms   = {1'b0, item_dur_x8(dur_cur)} + {3'b0, dur_cur, 1'b0};
  assign slot_inc = slot_r + 1'b1;

  assign hdr_we     = in_fire && (act == ACT_WR_HDR);
  assign slot_we    = in_fire && (act == ACT_WR_SLOT) && (item.slot_index != '0);
  assign slot_waddr = {item.pattern, item.slot_index};

  always_comb begin
    line_nxt     = line_r;
    slot_nxt     = slot_r;
    round_nxt    = round_r;
    sv_line_nxt  = sv_line_r;
    sv_slot_nxt  = sv_slot_r;
    sv_round_nxt = sv_round_r;
    cd_nxt       = cd_r;
    led_nxt      = led_r;
    if (in_fire) begin
      case (act)
        ACT_TICK: begin
          cd_nxt = cd_dec;
          if (cd_dec == '0 && line_r != '0) begin
            if (slot_r >= hdr_cur.slot_count) begin
              // end of round: repeat, resume the saved pattern, or go idle
              if (hdr_cur.repeats == '0 || hdr_cur.repeats > round_r) begin
                round_nxt = round_r + 1'b1;
                slot_nxt  = '0;
              end else if (sv_line_r != '0) begin
                line_nxt     = sv_line_r;
                slot_nxt     = sv_slot_r;
                round_nxt    = sv_round_r;
                sv_line_nxt  = '0;
                sv_slot_nxt  = '0;
                sv_round_nxt = '0;
              end else begin
                line_nxt = '0;
              end
            end else begin
              slot_nxt = slot_inc;
              cd_nxt   = dur_ms;
              if (slot_inc[0]) begin
                led_nxt = led_r | {hdr_cur.green_en, hdr_cur.red_en};
              end else begin
                led_nxt = 2'b00;
              end
            end
          end
        end
        ACT_START: begin
          if (item.pattern == '0) begin
            sv_line_nxt = '0;
          end
          if (line_r == '0 || hdr_cur.prio != PRIO_LOCK) begin
            if (line_r != '0 && hdr_cur.prio == PRIO_SAVE) begin
              sv_line_nxt  = line_r;
              sv_slot_nxt  = slot_r;
              sv_round_nxt = round_r;
            end
            line_nxt  = item.pattern;
            slot_nxt  = '0;
            round_nxt = 8'd1;
            led_nxt   = 2'b00;
            cd_nxt    = START_GAP_MS;
          end
        end
        ACT_STOP: begin
          line_nxt = '0;
          cd_nxt   = '0;
          led_nxt  = 2'b00;
        end
        default: ;
      endcase
      // unfitted LEDs are never driven
      led_nxt = led_nxt & {green_fitted_r, red_fitted_r};
    end
  end

  // Prefetch the duration for the slot after the next state's slot.
  assign slot_raddr = {line_nxt, slot_nxt + 1'b1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r     <= '0;
      slot_r     <= '0;
      round_r    <= '0;
      sv_line_r  <= '0;
      sv_slot_r  <= '0;
      sv_round_r <= '0;
      cd_r       <= '0;
      led_r      <= '0;
      slot_vld_r <= '0;
      rd_vld_r   <= 1'b0;
      fwd_hit_r  <= 1'b0;
      for (int i = 0; i < NUM_PATS; i++) begin
        hdr_r[i] <= '0;
      end
    end else begin
      line_r     <= line_nxt;
      slot_r     <= slot_nxt;
      round_r    <= round_nxt;
      sv_line_r  <= sv_line_nxt;
      sv_slot_r  <= sv_slot_nxt;
      sv_round_r <= sv_round_nxt;
      cd_r       <= cd_nxt;
      led_r      <= led_nxt;
      if (hdr_we) begin
        hdr_r[item.pattern] <= {item.repeats, item.green_enable, item.red_enable,
                                item.priority_req, item.slot_count};
      end
      if (slot_we) begin
        slot_vld_r[slot_waddr] <= 1'b1;
      end
      rd_vld_r  <= slot_vld_r[slot_raddr];
      // same-cycle write to the prefetched entry: forward the new data
      fwd_hit_r <= slot_we && (slot_waddr == slot_raddr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= item.duration;
  end

  // ---------------------------------------------------------------------------
  // Result register plus skid register
  // ---------------------------------------------------------------------------
  out_item_t res_new;
  out_item_t out_r, skid_r;
  logic      out_vld_r, skid_vld_r;

  always_comb begin
    res_new.pad            = 1'b0;
    res_new.active_pattern = line_nxt;
    res_new.busy_res       = (line_nxt != '0);
    res_new.green_led      = led_nxt[1];
    res_new.red_led        = led_nxt[0];
  end

  assign in_tready  = !skid_vld_r;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (in_fire) begin
      // skid is empty whenever an item is accepted
      if (!out_vld_r || out_fire) begin
        out_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_vld_r  <= skid_vld_r;
      skid_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (!out_vld_r || out_fire) begin
        out_r <= res_new;
      end else begin
        skid_r <= res_new;
      end
    end else if (out_fire && skid_vld_r) begin
      out_r <= skid_r;
    end
  end

endmodule

@@ rtl/lbps_checker.sv @@
// Port-level checker for the LED blink pattern sequencer, bound to the top level.
// Depends on lbps_pkg.
module lbps_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [2:0] in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);
  import lbps_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Busy flag agrees with the active pattern number.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2] == (out_tdata[6:3] != 4'd0)))
    else $error("busy flag disagrees with active pattern");

  // Input stalls only when both result slots are full.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output");

  // A stop taken on an empty output shows an idle, dark result next cycle.
  a_stop: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == ACT_STOP) && !out_tvalid
    |=> out_tvalid && (out_tdata[2:0] == 3'b000))
    else $error("stop did not clear the result");

endmodule

bind led_blink_pattern_sequencer lbps_checker u_lbps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ sim/testbench.sv @@
// Self-checking testbench for the LED blink pattern sequencer (led_blink_pattern_sequencer).
// Holds a cycle-free predictor of the sequencer, stream driver/monitor and phased stimulus.
// Depends on rtl/lbps_pkg.sv and rtl/led_blink_pattern_sequencer.sv.
`timescale 1ns / 100ps

module testbench;
  import lbps_pkg::*;

  // Register indexes on the configuration port.
  localparam logic CFG_RED_FITTED   = 1'b0;
  localparam logic CFG_GREEN_FITTED = 1'b1;

  // The last action code the block ignores, and the priority codes treated as replaceable.
  localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
  localparam logic [1:0] PRIO_REPLACE    = 2'd0;
  localparam logic [1:0] PRIO_SPARE      = 2'd3;

  localparam logic [CD_W-1:0] MS_PER_UNIT = 12'd10;

  localparam int unsigned HALF_PHASE_ITEMS = 22;
  localparam int unsigned HOLD_CYCLES      = 60;
  localparam int unsigned STALL_LIMIT      = 2000;

  typedef struct {
    logic [2:0] act;
    in_item_t   f;
  } blink_cmd_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;  // pattern, slot_index, duration, slot_count,
                                 // priority_req, repeats, red_enable, green_enable
  logic [2:0]  in_tuser   = '0;  // action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;        // red_led, green_led, busy_res, active_pattern, zero pad
  logic        cfg_wr_en  = 1'b0;
  logic        cfg_addr   = 1'b0;
  logic        cfg_wdata  = 1'b0;

  led_blink_pattern_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of everything the sequencer remembers.
  // ---------------------------------------------------------------------------
  logic            fit_red, fit_green;
  logic [3:0]      run_line, run_slot;
  logic [7:0]      run_round;
  logic [3:0]      held_line, held_slot;
  logic [7:0]      held_round;
  logic [CD_W-1:0] ms_left;
  logic [1:0]      led_on;        // bit 0 red, bit 1 green
  header_t         hdr_table [NUM_PATS];
  logic [7:0]      dur_table [SLOT_DEPTH];

  // Stimulus waiting for the driver, and LED results waiting for the monitor.
  blink_cmd_t  blink_cmd_q[$];
  out_item_t   led_expect_q[$];

  int unsigned queued_items   = 0;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_asked     = 0;
  int unsigned hold_served    = 0;
  int unsigned hold_left      = 0;
  logic        in_taken       = 1'b0;

  function automatic void clear_predictor();
    fit_red    = 1'b1;
    fit_green  = 1'b1;
    run_line   = '0;
    run_slot   = '0;
    run_round  = '0;
    held_line  = '0;
    held_slot  = '0;
    held_round = '0;
    ms_left    = '0;
    led_on     = '0;
    foreach (hdr_table[i]) hdr_table[i] = '0;
    foreach (dur_table[i]) dur_table[i] = '0;
  endfunction

  // One sequencing step: either close the round or advance to the next slot.
  function automatic void sequence_step();
    header_t h;
    if (run_line == '0) return;
    h = hdr_table[run_line];
    if (run_slot >= h.slot_count) begin
      if (h.repeats == '0 || h.repeats > run_round) begin
        run_round = run_round + 8'd1;
        run_slot  = '0;
      end else if (held_line != '0) begin
        // Resume the interrupted pattern, then forget the saved copy.
        run_line   = held_line;
        run_slot   = held_slot;
        run_round  = held_round;
        held_line  = '0;
        held_slot  = '0;
        held_round = '0;
      end else begin
        run_line = '0;
      end
      return;
    end
    run_slot = run_slot + 4'd1;
    ms_left  = CD_W'(dur_table[{run_line, run_slot}]) * MS_PER_UNIT;
    if (run_slot[0]) begin
      if (h.red_en && fit_red)     led_on[0] = 1'b1;
      if (h.green_en && fit_green) led_on[1] = 1'b1;
    end else begin
      led_on = '0;
    end
  endfunction

  function automatic void start_blink(logic [3:0] pat);
    if (pat == '0) held_line = '0;
    if (run_line != '0) begin
      if (hdr_table[run_line].prio == PRIO_SAVE) begin
        held_line  = run_line;
        held_slot  = run_slot;
        held_round = run_round;
      end else if (hdr_table[run_line].prio == PRIO_LOCK) begin
        return;
      end
    end
    run_line  = pat;
    run_slot  = '0;
    run_round = 8'd1;
    led_on    = '0;
    ms_left   = START_GAP_MS;
  endfunction

  // Apply one accepted item to the predictor and return the LED result it causes.
  function automatic out_item_t predict_led_item(logic [2:0] act, in_item_t f);
    out_item_t r;
    case (act)
      ACT_TICK: begin
        if (ms_left != '0) ms_left = ms_left - 1'b1;
        if (ms_left == '0) sequence_step();
      end
      ACT_START: start_blink(f.pattern);
      ACT_STOP: begin
        run_line = '0;
        ms_left  = '0;
        led_on   = '0;
      end
      ACT_WR_HDR:
        hdr_table[f.pattern] = {f.repeats, f.green_enable, f.red_enable,
                                f.priority_req, f.slot_count};
      ACT_WR_SLOT:
        if (f.slot_index != '0) dur_table[{f.pattern, f.slot_index}] = f.duration;
      default: ;
    endcase
    if (!fit_red)   led_on[0] = 1'b0;
    if (!fit_green) led_on[1] = 1'b0;
    r                = '0;
    r.red_led        = led_on[0];
    r.green_led      = led_on[1];
    r.busy_res       = (run_line != '0);
    r.active_pattern = run_line;
    return r;
  endfunction

  function automatic void check_led_field(string what, logic [3:0] want, logic [3:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      mismatch_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders: all of them only append to the pending queue.
  // ---------------------------------------------------------------------------
  function automatic void push_cmd(logic [2:0] act, in_item_t f);
    blink_cmd_t c;
    c.act = act;
    c.f   = f;
    blink_cmd_q.push_back(c);
    queued_items++;
  endfunction

  // Random filler, so that bits a command does not use still toggle.
  function automatic in_item_t random_fields();
    logic [31:0] r;
    r = $urandom;
    return in_item_t'(r);
  endfunction

  function automatic in_item_t make_fields(logic [3:0] pat, logic [3:0] sidx, logic [7:0] dur,
                                           logic [3:0] cnt, logic [1:0] prio, logic [7:0] rep,
                                           logic ren, logic gen);
    in_item_t f;
    f.pattern      = pat;
    f.slot_index   = sidx;
    f.duration     = dur;
    f.slot_count   = cnt;
    f.priority_req = prio;
    f.repeats      = rep;
    f.red_enable   = ren;
    f.green_enable = gen;
    return f;
  endfunction

  function automatic void push_ticks(int unsigned n);
    repeat (n) push_cmd(ACT_TICK, random_fields());
  endfunction

  // A well-formed run: optionally stop, (re)load a short pattern, start it, let it
  // play, and sometimes interrupt it with another start so save/resume gets exercised.
  function automatic void queue_pattern_run();
    in_item_t    f;
    logic [3:0]  pat;
    int unsigned len;
    if ($urandom_range(9) < 6) push_cmd(ACT_STOP, random_fields());
    pat = 4'($urandom_range(1, 15));
    if ($urandom_range(3) != 0) begin
      len = ($urandom_range(19) == 0) ? 15 : $urandom_range(4);
      f = random_fields();
      f.pattern      = pat;
      f.slot_count   = 4'(len);
      f.priority_req = 2'($urandom_range(3));
      case ($urandom_range(15))
        0, 1:    f.repeats = '0;
        2:       f.repeats = 8'($urandom);
        default: f.repeats = 8'($urandom_range(1, 3));
      endcase
      push_cmd(ACT_WR_HDR, f);
      for (int unsigned s = 1; s <= len; s++) begin
        f = random_fields();
        f.pattern    = pat;
        f.slot_index = 4'(s);
        // Keep slots short; a long one now and then stretches the countdown.
        if ($urandom_range(39) == 0)     f.duration = 8'($urandom);
        else if ($urandom_range(3) == 0) f.duration = 8'd2;
        else                             f.duration = 8'($urandom_range(1));
        push_cmd(ACT_WR_SLOT, f);
      end
    end
    f = random_fields();
    f.pattern = pat;
    push_cmd(ACT_START, f);
    push_ticks($urandom_range(10, 35));
    if ($urandom_range(9) < 4) begin
      f = random_fields();
      f.pattern = 4'($urandom_range(15));
      push_cmd(ACT_START, f);
      push_ticks($urandom_range(10, 30));
    end
  endfunction

  // Noise: any action code, spare ones included, with fully random fields.
  function automatic void queue_random_cmd();
    repeat ($urandom_range(1, 3))
      push_cmd(3'($urandom_range(ACT_SPARE_LAST)), random_fields());
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present the next pending item at the falling edge; hold it until taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    blink_cmd_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (blink_cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        c = blink_cmd_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= c.f;
        in_tuser  <= c.act;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when the sequence asks for one.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (hold_asked != hold_served) begin
      hold_served++;
      hold_left = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check results against the oldest expectation first, then predict
  // for an item taken at the same edge. Also run the no-progress watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t got, want;
    logic      out_taken;
    if (!rst_n) begin
      in_taken = 1'b0;
    end else begin
      in_taken  = in_tvalid && in_tready;
      out_taken = out_tvalid && out_tready;
      if (out_taken) begin
        got = out_tdata;
        if (led_expect_q.size() == 0) begin
          $display("%0t: result expected none, got %h", $time, out_tdata);
          mismatch_count++;
        end else begin
          want = led_expect_q.pop_front();
          check_led_field("red_led", 4'(want.red_led), 4'(got.red_led));
          check_led_field("green_led", 4'(want.green_led), 4'(got.green_led));
          check_led_field("busy_res", 4'(want.busy_res), 4'(got.busy_res));
          check_led_field("active_pattern", want.active_pattern, got.active_pattern);
          check_led_field("pad", 4'(want.pad), 4'(got.pad));
        end
      end
      if (in_taken)
        led_expect_q.push_back(predict_led_item(in_tuser, in_tdata));

      if (in_taken || out_taken || cfg_wr_en) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Write both fitted flags while the block is idle; mirror them in the predictor.
  task automatic write_fitted(logic red, logic green);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= CFG_RED_FITTED;
    cfg_wdata <= red;
    @(negedge clk);
    cfg_addr  <= CFG_GREEN_FITTED;
    cfg_wdata <= green;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    fit_red   = red;
    fit_green = green;
  endtask

  // Pause the sender until every item is taken and every result has come back.
  task automatic wait_results_drained();
    do @(posedge clk);
    while (blink_cmd_q.size() != 0 || in_tvalid || led_expect_q.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed items, then random phases over settings and idling.
  // ---------------------------------------------------------------------------
  initial begin
    logic [1:0] fit_plan [8];
    int         k, half;
    fit_plan = '{2'b00, 2'b01, 2'b10, 2'b11, 2'b00, 2'b11, 2'b01, 2'b11};
    clear_predictor();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_fitted(1'b1, 1'b1);

    // Directed: idle tick, start of "none", table loads with field extremes,
    // ignored slot position, a save, a locked pattern, stop, spare code.
    push_cmd(ACT_TICK, make_fields(4'd0, 4'd0, 8'd0, 4'd0, PRIO_REPLACE, 8'd0, 1'b0, 1'b0));
    push_cmd(ACT_START, make_fields(4'd0, 4'd0, 8'd0, 4'd0, PRIO_REPLACE, 8'd0, 1'b0, 1'b0));
    push_cmd(ACT_WR_HDR, make_fields(4'd1, 4'd0, 8'd0, 4'd3, PRIO_SAVE, 8'd1, 1'b1, 1'b1));
    push_cmd(ACT_WR_SLOT, make_fields(4'd1, 4'd1, 8'd0, 4'd0, PRIO_REPLACE, 8'd0, 1'b0, 1'b0));
    push_cmd(ACT_WR_SLOT, make_fields(4'd1, 4'd2, 8'd0, 4'd0, PRIO_REPLACE, 8'd0, 1'b0, 1'b0));
    push_cmd(ACT_WR_SLOT, make_fields(4'd1, 4'd3, 8'd1, 4'd0, PRIO_REPLACE, 8'd0, 1'b0, 1'b0));
    push_cmd(ACT_WR_SLOT, make_fields(4'd1, 4'd0, 8'd255, 4'd0, PRIO_REPLACE, 8'd0, 1'b0, 1'b0));
    push_cmd(ACT_WR_SLOT, make_fields(4'd15, 4'd15, 8'd255, 4'd0, PRIO_REPLACE, 8'd0, 1'b0, 1'b0));
    push_cmd(ACT_WR_HDR, make_fields(4'd15, 4'd0, 8'd0, 4'd15, PRIO_SPARE, 8'd255, 1'b1, 1'b1));
    push_cmd(ACT_WR_HDR, make_fields(4'd2, 4'd0, 8'd0, 4'd1, PRIO_LOCK, 8'd2, 1'b1, 1'b0));
    push_cmd(ACT_WR_SLOT, make_fields(4'd2, 4'd1, 8'd0, 4'd0, PRIO_REPLACE, 8'd0, 1'b0, 1'b0));
    push_cmd(ACT_START, make_fields(4'd1, 4'd0, 8'd0, 4'd0, PRIO_REPLACE, 8'd0, 1'b0, 1'b0));
    // Wait out the start gap; the last two ticks light and then clear the LEDs.
    push_ticks(11);
    push_cmd(ACT_START, make_fields(4'd2, 4'd0, 8'd0, 4'd0, PRIO_REPLACE, 8'd0, 1'b0, 1'b0));
    push_cmd(ACT_START, make_fields(4'd1, 4'd0, 8'd0, 4'd0, PRIO_REPLACE, 8'd0, 1'b0, 1'b0));
    push_cmd(ACT_STOP, make_fields(4'd0, 4'd0, 8'd0, 4'd0, PRIO_REPLACE, 8'd0, 1'b0, 1'b0));
    push_cmd(ACT_SPARE_LAST, make_fields(4'd0, 4'd0, 8'd0, 4'd0, PRIO_REPLACE, 8'd0, 1'b0, 1'b0));
    push_cmd(ACT_START, make_fields(4'd15, 4'd0, 8'd0, 4'd0, PRIO_REPLACE, 8'd0, 1'b0, 1'b0));
    push_cmd(ACT_START, make_fields(4'd0, 4'd0, 8'd0, 4'd0, PRIO_REPLACE, 8'd0, 1'b0, 1'b0));
    push_cmd(ACT_STOP, make_fields(4'd0, 4'd0, 8'd0, 4'd0, PRIO_REPLACE, 8'd0, 1'b0, 1'b0));
    wait_results_drained();

    // Random phases: new fitted flags each phase (bit 0 red, bit 1 green),
    // idling mode cycling through none / sender / receiver / both.
    for (k = 0; k < 8; k++) begin
      write_fitted(fit_plan[k][0], fit_plan[k][1]);
      case (k % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      for (half = 0; half < 2; half++) begin
        queued_items = 0;
        while (queued_items < HALF_PHASE_ITEMS) begin
          if ($urandom_range(9) < 8) queue_pattern_run();
          else queue_random_cmd();
        end
        // Block the result side for a long stretch while items keep coming.
        if (half == 0 && send_idle_pct == 0) hold_asked++;
        wait_results_drained();
      end
    end

    // Let any stray result surface before the verdict.
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
